### rtl/jep_pkg.sv
// Joystick event packetizer: shared types, register indexes, frame constants
// and the button code table. No dependencies.
package jep_pkg;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 12;
  localparam int DZ_W        = 8;
  localparam int CENTER_W    = 12;
  localparam int BYTE_W      = 8;
  localparam int VALUE_W     = 16;
  localparam int FRAME_BYTES = 4;
  localparam int BIDX_W      = 3;
  localparam int NUM_BUTTONS = 6;

  // scale by 255/2048: (x << 8) - x, then shift right by 11
  localparam int SCALE_MUL_SH = 8;
  localparam int SCALE_SHIFT  = 11;
  localparam int ROUND_ADD    = (1 << SCALE_SHIFT) - 1;

  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER   = 2'd1;

  localparam logic [DZ_W-1:0]     DEADZONE_RST = 8'd30;
  localparam logic [CENTER_W-1:0] CENTER_RST   = 12'd2048;

  localparam logic [BYTE_W-1:0] CODE_X     = 8'd0;
  localparam logic [BYTE_W-1:0] CODE_Y     = 8'd1;
  localparam logic [BYTE_W-1:0] TERMINATOR = 8'hFF;

  typedef enum logic [1:0] {
    KIND_X    = 2'd0,
    KIND_Y    = 2'd1,
    KIND_BTN  = 2'd2,
    KIND_RSVD = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [BIDX_W-1:0] bidx;
    logic              falling;
  } meta_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  code;
    logic [VALUE_W-1:0] value;
  } frame_t;

  function automatic logic [BYTE_W-1:0] button_code(input logic [BIDX_W-1:0] idx);
    logic [BYTE_W-1:0] code;
    case (idx)
      3'd0:    code = 8'd7;
      3'd1:    code = 8'd2;
      3'd2:    code = 8'd3;
      3'd3:    code = 8'd4;
      3'd4:    code = 8'd5;
      3'd5:    code = 8'd6;
      default: code = 8'd0;
    endcase
    return code;
  endfunction

endpackage

### rtl/jep_intf.sv
// Joystick event packetizer: valid/ready channel interfaces for input events,
// output frame bytes and register writes. Depends on jep_pkg.
interface jep_in_if #(parameter int SAMPLE_BITS = 12) ();
  import jep_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             kind;
  logic [SAMPLE_BITS-1:0] sample;
  logic [BIDX_W-1:0]      button_index;
  logic                   falling;

  modport source (output valid, kind, sample, button_index, falling, input ready);
  modport sink   (input valid, kind, sample, button_index, falling, output ready);
endinterface

interface jep_out_if ();
  import jep_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

interface jep_cfg_if ();
  import jep_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/jep_cell.sv
// Joystick event packetizer: one sample cell of an axis window chain.
// Takes its neighbor's sample on a push. No dependencies.
module jep_cell #(
  parameter int W = 12
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         shift_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] smp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_q <= '0;
    end else if (shift_i) begin
      smp_q <= d_i;
    end
  end

  assign q_o = smp_q;

endmodule

### rtl/jep_axis_ring.sv
// Joystick event packetizer: window of samples for one axis as a chain of
// cells, plus a running sum. Depends on jep_cell.
module jep_axis_ring #(
  parameter int WINDOW      = 5,
  parameter int SAMPLE_BITS = 12,
  parameter int SUM_W       = SAMPLE_BITS + $clog2(WINDOW)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic [SUM_W-1:0]       sum_o
);

  logic [SAMPLE_BITS-1:0] tap [WINDOW+1];
  logic [SUM_W-1:0]       sum_q, sum_d;

  assign tap[0] = sample_i;

  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    jep_cell #(.W(SAMPLE_BITS)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(push_i),
      .d_i    (tap[k]),
      .q_o    (tap[k+1])
    );
  end

  // the oldest sample drops off the far end of the chain
  assign sum_d = sum_q + SUM_W'(sample_i) - SUM_W'(tap[WINDOW]);
  assign sum_o = sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (push_i) begin
      sum_q <= sum_d;
    end
  end

endmodule

### rtl/jep_serializer.sv
// Joystick event packetizer: 4-byte frame output register, shifted out one
// word per handshake. Depends on jep_pkg and jep_out_if.
module jep_serializer import jep_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  frame_t    frame_i,
  output logic      can_load_o,
  jep_out_if.source out_o
);

  localparam int CNT_W = $clog2(FRAME_BYTES + 1);

  logic [BYTE_W-1:0] byte_q [FRAME_BYTES];
  logic [CNT_W-1:0]  cnt_q;
  logic              out_fire;

  assign out_o.valid    = (cnt_q != '0);
  assign out_o.out_byte = byte_q[0];
  assign out_o.last     = (cnt_q == CNT_W'(1));
  assign out_fire       = out_o.valid && out_o.ready;
  assign can_load_o     = (cnt_q == '0) || (out_o.last && out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= CNT_W'(FRAME_BYTES);
    end else if (out_fire) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      byte_q[0] <= frame_i.code;
      byte_q[1] <= frame_i.value[BYTE_W-1:0];
      byte_q[2] <= frame_i.value[VALUE_W-1:BYTE_W];
      byte_q[3] <= TERMINATOR;
    end else if (out_fire) begin
      for (int k = 0; k < FRAME_BYTES - 1; k++) begin
        byte_q[k] <= byte_q[k+1];
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(FRAME_BYTES))
    else $error("frame byte count out of range");

  a_last_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.last |-> out_o.out_byte == TERMINATOR)
    else $error("last word is not the terminator");

  a_load_show: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> out_o.valid && !out_o.last && out_o.out_byte == $past(frame_i.code))
    else $error("loaded frame does not open with its code");
`endif

endmodule

### rtl/joystick_event_packetizer.sv
// Joystick event packetizer top level: axis windows, averaging and scaling
// pipeline, register port and frame output. Depends on jep_pkg, jep_intf,
// jep_axis_ring and jep_serializer.
//
//  channel | dir | words per item   | payload
//  in_i    | in  | 1                | kind, sample, button_index, falling
//  out_o   | out | 0 or 4 per event | out_byte, last
//  cfg_i   | in  | 1 per write      | index, data (always ready)
//
// A frame-producing event occupies the output register until its 4 words are
// taken; events that give no frame pass at 1 per cycle unless held behind a
// frame waiting for the output register. The output serializer sets the rate.
// The first word is registered through the window sum at the accepting edge,
// then reciprocal multiply, center and x255, round and deadzone, frame register.
// Reset clears the sample windows and sums at once; no sweep is needed.
// A stall on out_o backs up the 4 stages, then drops in_i.ready.
module joystick_event_packetizer import jep_pkg::*; #(
  parameter int WINDOW      = 5,
  parameter int SAMPLE_BITS = 12
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  jep_in_if.sink   in_i,
  jep_out_if.source out_o,
  jep_cfg_if.sink  cfg_i
);

  localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW);
  localparam int DIV_S   = SUM_W + $clog2(WINDOW);
  localparam int M_W     = SUM_W + 1;
  localparam int MUL_W   = SUM_W + M_W;
  localparam int DELTA_W = ((SAMPLE_BITS > CENTER_W) ? SAMPLE_BITS : CENTER_W) + 1;
  localparam int P_W     = DELTA_W + SCALE_MUL_SH;
  localparam int SC_W    = P_W - SCALE_SHIFT;
  localparam logic [M_W-1:0] RECIP_M =
    M_W'(((64'd1 << DIV_S) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  // registers
  logic [DZ_W-1:0]     deadzone_q;
  logic [CENTER_W-1:0] center_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q <= DEADZONE_RST;
      center_q   <= CENTER_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_DEADZONE: deadzone_q <= cfg_i.data[DZ_W-1:0];
        REG_CENTER:   center_q   <= cfg_i.data[CENTER_W-1:0];
        default:      ;
      endcase
    end
  end

  // pipeline handshake
  logic   v1_q, v2_q, v3_q, v4_q;
  logic   take1, take2, take3, take4;
  logic   in_fire, s4_out, ser_load, ser_can_load;
  logic   s4_emit_q;
  kind_e  in_kind;
  meta_t  in_meta;

  assign in_kind = kind_e'(in_i.kind);
  assign in_meta = '{kind: in_kind, bidx: in_i.button_index, falling: in_i.falling};

  assign s4_out   = v4_q && (!s4_emit_q || ser_can_load);
  assign ser_load = v4_q && s4_emit_q && ser_can_load;
  assign take4    = !v4_q || s4_out;
  assign take3    = !v3_q || take4;
  assign take2    = !v2_q || take3;
  assign take1    = !v1_q || take2;

  assign in_i.ready = take1;
  assign in_fire    = in_i.valid && take1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (take1) v1_q <= in_i.valid;
      if (take2) v2_q <= v1_q;
      if (take3) v3_q <= v2_q;
      if (take4) v4_q <= v3_q;
    end
  end

  // axis windows
  logic [SUM_W-1:0] x_sum, y_sum;

  jep_axis_ring #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS), .SUM_W(SUM_W)) u_x_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_fire && in_kind == KIND_X),
    .sample_i(in_i.sample),
    .sum_o   (x_sum)
  );

  jep_axis_ring #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS), .SUM_W(SUM_W)) u_y_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_fire && in_kind == KIND_Y),
    .sample_i(in_i.sample),
    .sum_o   (y_sum)
  );

  // stage 1: window sum
  meta_t            s1_meta_q;
  logic [SUM_W-1:0] s1_sum_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_meta_q <= in_meta;
      s1_sum_q  <= (in_kind == KIND_Y) ? y_sum : x_sum;
    end
  end

  // stage 2: average by reciprocal multiply, exact for all sums
  meta_t                  s2_meta_q;
  logic [SAMPLE_BITS-1:0] s2_avg_q;
  logic [MUL_W-1:0]       avg_prod;

  assign avg_prod = MUL_W'(s1_sum_q) * MUL_W'(RECIP_M);

  always_ff @(posedge clk_i) begin
    if (take2 && v1_q) begin
      s2_meta_q <= s1_meta_q;
      s2_avg_q  <= avg_prod[DIV_S +: SAMPLE_BITS];
    end
  end

  // stage 3: subtract center, times 255
  meta_t                     s3_meta_q;
  logic signed [P_W-1:0]     s3_prod_q;
  logic signed [DELTA_W-1:0] delta;
  logic signed [P_W-1:0]     delta_x;

  assign delta   = $signed(DELTA_W'(s2_avg_q)) - $signed(DELTA_W'(center_q));
  assign delta_x = P_W'(delta);

  always_ff @(posedge clk_i) begin
    if (take3 && v2_q) begin
      s3_meta_q <= s2_meta_q;
      s3_prod_q <= (delta_x <<< SCALE_MUL_SH) - delta_x;
    end
  end

  // stage 4: divide by 2048 toward zero, deadzone, build frame
  logic signed [P_W-1:0]     rnd;
  logic signed [SC_W-1:0]    scaled;
  logic [SC_W-1:0]           mag;
  logic signed [VALUE_W-1:0] axis_val;
  logic                      axis_emit;
  frame_t                    frame_d, s4_frame_q;
  logic                      emit_d;

  assign rnd       = s3_prod_q[P_W-1] ? (s3_prod_q + P_W'(ROUND_ADD)) : s3_prod_q;
  assign scaled    = SC_W'(rnd >>> SCALE_SHIFT);
  assign mag       = scaled[SC_W-1] ? SC_W'(-scaled) : SC_W'(scaled);
  assign axis_emit = !(mag < SC_W'(deadzone_q)) && (scaled != '0);
  assign axis_val  = VALUE_W'(scaled);

  always_comb begin
    frame_d = '0;
    emit_d  = 1'b0;
    case (s3_meta_q.kind)
      KIND_X: begin
        frame_d.code  = CODE_X;
        frame_d.value = axis_val;
        emit_d        = axis_emit;
      end
      KIND_Y: begin
        frame_d.code  = CODE_Y;
        frame_d.value = -axis_val;
        emit_d        = axis_emit;
      end
      KIND_BTN: begin
        frame_d.code  = button_code(s3_meta_q.bidx);
        frame_d.value = VALUE_W'(s3_meta_q.falling);
        emit_d        = (s3_meta_q.bidx < BIDX_W'(NUM_BUTTONS));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (take4 && v3_q) begin
      s4_frame_q <= frame_d;
      s4_emit_q  <= emit_d;
    end
  end

  // output register
  jep_serializer u_ser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (ser_load),
    .frame_i   (s4_frame_q),
    .can_load_o(ser_can_load),
    .out_o     (out_o)
  );

endmodule
